// ===== rtl/core/rbd_pkg.sv =====
// Shared types and constants for the ring buffer deque.
package rbd_pkg;

   localparam int unsigned DEPTH     = 16;
   localparam int unsigned IDX_W     = $clog2(DEPTH);
   localparam int unsigned CNT_W     = IDX_W + 1;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned OP_W      = 2;
   localparam int unsigned STATUS_W  = 2;

   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_TAIL = 2'd0,
      OP_PUSH_HEAD = 2'd1,
      OP_POP_TAIL  = 2'd2,
      OP_POP_HEAD  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_HOLD = 1'b1
   } ctl_state_type;

endpackage

// ===== rtl/core/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: double-ended queue of 32-bit words.
//
// Usage:
//   req channel  - one word per operation. tuser carries the operation code
//                  (push tail, push head, pop tail, pop head), tdata the word
//                  to push (ignored on pops).
//   rsp channel  - exactly one result word per request word: popped value
//                  (all ones on underflow, zero on pushes) and the count left
//                  in the queue in tdata, the outcome code in tuser.
//   csr port     - write the capacity (1..16) while the queue is empty; zero
//                  takes effect as one, anything above sixteen as sixteen,
//                  and a write while words are stored is dropped.
// Timing: a request is executed in the cycle it is accepted and its result
//   sits in the output register from the next cycle. A new request is taken
//   in the same cycle the waiting result leaves, so with the receiver always
//   ready the block sustains one word per cycle.
// Stall: while the receiver holds rsp_tready low the result is held and
//   req_tready stays low, so no word is lost or overtaken.
// Reset: pointers and count clear, capacity returns to sixteen, no result is
//   pending. Slot contents are not cleared; only pushed words are ever read.
module ring_buffer_deque (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] pop_value, [36:32] occupancy, [39:37] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration
   input  logic        csr_wen,
   input  logic [4:0]  csr_wdata    // [4:0] capacity
);

   logic                                exec;
   logic [rbd_pkg::WORD_W-1:0]          pop_value;
   rbd_pkg::status_type                 status;
   logic [rbd_pkg::CNT_W-1:0]           occupancy;

   // handshake and sequencing
   rbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .exec       (exec)
   );

   // store, pointers and result register
   rbd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .exec       (exec),
      .op         (rbd_pkg::op_type'(req_tuser)),
      .push_value (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .pop_value  (pop_value),
      .status     (status),
      .occupancy  (occupancy)
   );

   // pack the result word, zero fill to whole bytes
   assign rsp_tdata = {3'b000, occupancy, pop_value};
   assign rsp_tuser = status;

endmodule

// ===== rtl/core/rbd_ctrl.sv =====
// Handshake controller: accepts a word, fires the datapath and holds the result word.
module rbd_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic exec
);

   rbd_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbd_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      exec       = 1'b0;
      case (state_ff)
         rbd_pkg::CTL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               exec     = 1'b1;
               state_in = rbd_pkg::CTL_HOLD;
            end
         end
         rbd_pkg::CTL_HOLD: begin
            rsp_tvalid = 1'b1;
            // a result word leaving frees the output register for the next word
            req_tready = rsp_tready;
            exec       = rsp_tready & req_tvalid;
            if (rsp_tready && !req_tvalid) begin
               state_in = rbd_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = rbd_pkg::CTL_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/rbd_datapath.sv =====
// Deque datapath: slot store, head and tail pointers, count, capacity and result register.
module rbd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              exec,
   input  rbd_pkg::op_type                   op,
   input  logic [rbd_pkg::WORD_W-1:0]        push_value,
   input  logic                              csr_wen,
   input  logic [rbd_pkg::CNT_W-1:0]         csr_wdata,
   output logic [rbd_pkg::WORD_W-1:0]        pop_value,
   output rbd_pkg::status_type               status,
   output logic [rbd_pkg::CNT_W-1:0]         occupancy
);

   logic [rbd_pkg::WORD_W-1:0] slots_ff [rbd_pkg::DEPTH];
   logic [rbd_pkg::IDX_W-1:0]  front_ff, front_in;
   logic [rbd_pkg::IDX_W-1:0]  back_ff, back_in;
   logic [rbd_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [rbd_pkg::CNT_W-1:0]  cap_ff, cap_in;

   logic [rbd_pkg::WORD_W-1:0] pop_value_ff, pop_value_in;
   rbd_pkg::status_type        status_ff, status_in;

   logic                       wr_en;
   logic [rbd_pkg::IDX_W-1:0]  wr_idx;

   logic [rbd_pkg::CNT_W-1:0]  back_up, front_up;
   logic [rbd_pkg::IDX_W-1:0]  back_inc, back_dec, front_inc, front_dec, cap_last;
   logic                       empty, full;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff >= cap_ff);
   assign cap_last  = rbd_pkg::IDX_W'(cap_ff - 1'b1);
   assign back_up   = {1'b0, back_ff} + 1'b1;
   assign front_up  = {1'b0, front_ff} + 1'b1;
   assign back_inc  = (back_up >= cap_ff) ? '0 : rbd_pkg::IDX_W'(back_up);
   assign front_inc = (front_up >= cap_ff) ? '0 : rbd_pkg::IDX_W'(front_up);
   assign back_dec  = (back_ff == '0) ? cap_last : back_ff - 1'b1;
   assign front_dec = (front_ff == '0) ? cap_last : front_ff - 1'b1;

   // clamp the written capacity into one..DEPTH; take it only while empty
   always_comb begin
      cap_in = cap_ff;
      if (csr_wen && empty) begin
         if (csr_wdata == '0) begin
            cap_in = rbd_pkg::CNT_W'(1);
         end else if (csr_wdata > rbd_pkg::CAP_MAX) begin
            cap_in = rbd_pkg::CAP_MAX;
         end else begin
            cap_in = csr_wdata;
         end
      end
   end

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      count_in     = count_ff;
      pop_value_in = '0;
      status_in    = rbd_pkg::ST_OK;
      wr_en        = 1'b0;
      wr_idx       = '0;
      case (op)
         rbd_pkg::OP_PUSH_TAIL, rbd_pkg::OP_PUSH_HEAD: begin
            if (full) begin
               status_in = rbd_pkg::ST_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (empty) begin
                  // restart both pointers at slot zero
                  front_in = '0;
                  back_in  = '0;
                  wr_idx   = '0;
               end else if (op == rbd_pkg::OP_PUSH_TAIL) begin
                  back_in = back_inc;
                  wr_idx  = back_inc;
               end else begin
                  front_in = front_dec;
                  wr_idx   = front_dec;
               end
            end
         end
         rbd_pkg::OP_POP_TAIL: begin
            if (empty) begin
               status_in    = rbd_pkg::ST_UNDERFLOW;
               pop_value_in = '1;
            end else begin
               pop_value_in = slots_ff[back_ff];
               back_in      = back_dec;
               count_in     = count_ff - 1'b1;
            end
         end
         rbd_pkg::OP_POP_HEAD: begin
            if (empty) begin
               status_in    = rbd_pkg::ST_UNDERFLOW;
               pop_value_in = '1;
            end else begin
               pop_value_in = slots_ff[front_ff];
               front_in     = front_inc;
               count_in     = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = rbd_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= rbd_pkg::CAP_MAX;
      end else begin
         cap_ff <= cap_in;
         if (exec) begin
            front_ff <= front_in;
            back_ff  <= back_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         pop_value_ff <= pop_value_in;
         status_ff    <= status_in;
         if (wr_en) begin
            slots_ff[wr_idx] <= push_value;
         end
      end
   end

   assign pop_value = pop_value_ff;
   assign status    = status_ff;
   assign occupancy = count_ff;

endmodule
